@@ hw/rtl/lks_pkg.sv @@
// ----------------------------------------------------------------------------
// lks_pkg
// Shared types and constants for the LRU key recency store.
// ----------------------------------------------------------------------------
package lks_pkg;

    localparam int ACT_W = 2;
    localparam int CAP_W = 4;
    localparam int OCC_W = 4;

    typedef enum logic [ACT_W-1:0] {
        ACT_GET      = 2'd0,
        ACT_PUT      = 2'd1,
        ACT_CONTAINS = 2'd2
    } action_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

endpackage

@@ hw/rtl/lru_key_recency_store_top.sv @@
// ----------------------------------------------------------------------------
// lru_key_recency_store_top
// Fully associative LRU store built as a row of key cells, most recent first.
// ----------------------------------------------------------------------------
// request path: an accepted request is captured in ST_IDLE; in ST_EXEC one
//   compare-and-shift pass across the cell row registers its result, held back
//   while an earlier result still waits for m_ready
// acceptance: no new request is taken until the current one has left ST_EXEC
// reset: occupancy cleared, capacity back to DEPTH capped at 8; keys are not cleared
// ----------------------------------------------------------------------------
module lru_key_recency_store_top #(
    parameter int DEPTH    = 8,
    parameter int KEY_BITS = 32
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [lks_pkg::CAP_W-1:0]  cfg_wdata,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [lks_pkg::ACT_W-1:0]  s_action,
    input  logic [KEY_BITS-1:0]        s_key,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic                       m_hit,
    output logic [lks_pkg::OCC_W-1:0]  m_occupancy
);

    import lks_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    cap_reg;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [ACT_W-1:0]    act_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic                m_valid_reg;
    logic                m_hit_reg;
    logic [OCC_W-1:0]    m_occupancy_reg;

    logic [CMP_W-1:0]    cap_ext;
    logic [CNT_W-1:0]    cap_live;
    logic                exec_fire;
    logic                found;
    logic                upd;
    logic                is_put;
    logic [IDX_W-1:0]    ins_pos;
    logic [DEPTH-1:0]    match;
    logic [DEPTH-1:0]    stop;
    logic [KEY_BITS-1:0] key_q [DEPTH];

    // capacity zero counts as one, above DEPTH saturates
    assign cap_ext  = CMP_W'(cfg_wdata);
    assign cap_live = (cap_ext == '0) ? CNT_W'(1)
                    : (cap_ext > CMP_W'(DEPTH)) ? CNT_W'(DEPTH)
                    : CNT_W'(cap_ext);

    // ------------------------------------------------------------------------
    // cell row
    // ------------------------------------------------------------------------
    assign found   = |match;
    assign is_put  = (act_reg == ACT_PUT);
    assign upd     = exec_fire && (is_put || ((act_reg == ACT_GET) && found));
    assign ins_pos = (count_reg >= cap_reg) ? IDX_W'(cap_reg - CNT_W'(1))
                                            : IDX_W'(count_reg);

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        lks_cell #(
            .KEY_BITS (KEY_BITS),
            .CNT_W    (CNT_W),
            .IDX_W    (IDX_W),
            .INDEX    (i)
        ) u_cell (
            .aclk     (aclk),
            .req_key  (key_reg),
            .key_in   ((i == 0) ? key_reg : key_q[(i == 0) ? 0 : i - 1]),
            .used     (count_reg),
            .found    (found),
            .upd      (upd),
            .ins_pos  (ins_pos),
            .stop_in  ((i == 0) ? 1'b0 : stop[(i == 0) ? 0 : i - 1]),
            .stop_out (stop[i]),
            .match    (match[i]),
            .key_out  (key_q[i])
        );
    end

    always_comb begin
        count_next = count_reg;
        if (is_put && !found && (count_reg < cap_reg)) begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    // ------------------------------------------------------------------------
    // control
    // ------------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready   = (state_reg == ST_IDLE);
        exec_fire = (state_reg == ST_EXEC) && (!m_valid_reg || m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cap_reg     <= CNT_W'(DEPTH < 8 ? DEPTH : 8);
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                cap_reg <= cap_live;
                if (count_reg > cap_live) begin
                    count_reg <= cap_live;
                end
            end else if (exec_fire) begin
                count_reg <= count_next;
            end
            if (exec_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            act_reg <= s_action;
            key_reg <= s_key;
        end
        if (exec_fire) begin
            m_hit_reg       <= found;
            m_occupancy_reg <= OCC_W'(count_next);
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_hit       = m_hit_reg;
    assign m_occupancy = m_occupancy_reg;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_count_in_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= cap_reg)
        else $error("occupancy above capacity");

    a_unique_keys: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EXEC) |-> $onehot0(match))
        else $error("key present in more than one slot");

    a_shift_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        upd |-> stop[DEPTH-1])
        else $error("row shift found no end slot");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        exec_fire |=> m_valid_reg && (state_reg == ST_IDLE))
        else $error("request finished without a result");

endmodule

@@ hw/rtl/lks_cell.sv @@
// ----------------------------------------------------------------------------
// lks_cell
// One recency slot: holds a key, compares it against the request and takes
// its neighbor's key when the row shifts through it.
// ----------------------------------------------------------------------------
module lks_cell #(
    parameter int KEY_BITS = 32,
    parameter int CNT_W    = 4,
    parameter int IDX_W    = 3,
    parameter int INDEX    = 0
) (
    input  logic                aclk,
    input  logic [KEY_BITS-1:0] req_key,
    input  logic [KEY_BITS-1:0] key_in,
    input  logic [CNT_W-1:0]    used,
    input  logic                found,
    input  logic                upd,
    input  logic [IDX_W-1:0]    ins_pos,
    input  logic                stop_in,
    output logic                stop_out,
    output logic                match,
    output logic [KEY_BITS-1:0] key_out
);

    logic [KEY_BITS-1:0] key_reg;
    logic                in_use;
    logic                at_pos;
    logic                shift;

    assign in_use   = CNT_W'(INDEX) < used;
    assign match    = in_use && (key_reg == req_key);
    // on a hit the row stops at the matching slot, otherwise at the insert slot
    assign at_pos   = found ? match : (ins_pos == IDX_W'(INDEX));
    assign shift    = upd && !stop_in;
    assign stop_out = stop_in || at_pos;
    assign key_out  = key_reg;

    always_ff @(posedge aclk) begin
        if (shift) begin
            key_reg <= key_in;
        end
    end

endmodule
